// ===== hdl/spi_pkg.sv =====
// ----------------------------------------------------------------------------
// spi_pkg
// Shared widths, reset values and types for the sparse pattern insert core.
// ----------------------------------------------------------------------------
package spi_pkg;

  // Fixed field widths of the ports
  localparam int DOF_W    = 13;
  localparam int SLOT_W_O = 15;
  localparam int LIMIT_W  = 15;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 15'd16384;

  // Write enables of the two pool arrays
  typedef struct packed {
    logic row;
    logic link;
  } pool_wen_t;

endpackage

// ===== hdl/spi_head_mem.sv =====
// ----------------------------------------------------------------------------
// spi_head_mem
// Column head table: one chain head per column, cleared by a sweep at reset.
// ----------------------------------------------------------------------------
module spi_head_mem
  import spi_pkg::*;
#(
  parameter int DEPTH  = 4096,
  parameter int SLOT_W = 15
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [SLOT_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [SLOT_W-1:0]        wr_data,
  output logic                     clearing
);

  localparam int AW = $clog2(DEPTH);

  logic [SLOT_W-1:0] mem [DEPTH];
  logic [AW-1:0]     clr_idx_r;
  logic              clr_busy_r;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [SLOT_W-1:0] wdata;

  assign clearing = clr_busy_r;

  always_comb begin
    if (clr_busy_r) begin
      we    = 1'b1;
      waddr = clr_idx_r;
      wdata = '0;
    end else begin
      we    = wr_en;
      waddr = wr_addr;
      wdata = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_idx_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/spi_pool_mem.sv =====
// ----------------------------------------------------------------------------
// spi_pool_mem
// Node pool: row number and next link of each entry, one read port shared.
// ----------------------------------------------------------------------------
module spi_pool_mem
  import spi_pkg::*;
#(
  parameter int DEPTH  = 16384,
  parameter int SLOT_W = 15
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DOF_W-1:0]         rd_row,
  output logic [SLOT_W-1:0]        rd_link,
  input  pool_wen_t                wen,
  input  logic [$clog2(DEPTH)-1:0] row_waddr,
  input  logic [DOF_W-1:0]         row_wdata,
  input  logic [$clog2(DEPTH)-1:0] link_waddr,
  input  logic [SLOT_W-1:0]        link_wdata
);

  logic [DOF_W-1:0]  row_mem  [DEPTH];
  logic [SLOT_W-1:0] link_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen.row) begin
      row_mem[row_waddr] <= row_wdata;
    end
    rd_row <= row_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wen.link) begin
      link_mem[link_waddr] <= link_wdata;
    end
    rd_link <= link_mem[rd_addr];
  end

endmodule

// ===== hdl/sparse_pattern_insert_core.sv =====
// ----------------------------------------------------------------------------
// sparse_pattern_insert_core
// Builds the nonzero pattern of a symmetric sparse matrix, one dof pair per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_dof_a / in_dof_b with start; the item is taken on a clock
//   edge with start high and busy low. One result per item is shown on the
//   out_* ports for exactly one cycle, flagged by out_valid; the receiver
//   cannot stall, so results must be captured when the strobe is seen.
//   Config: cfg_pool_limit is written on cfg_valid & cfg_ready (ready is
//   always high); write it only while the block is idle.
// Timing:
//   Out-of-range pair: result registered in the cycle after accept.
//   Empty column: column head table read, then allocate.
//   Chain walk: head table read, then a step per chain entry visited; each
//   step is one pool memory read, whose registered data feeds the next address.
//   Appending after a walk holds busy in ST_LINK0 (second link write).
//   Throughput is set by the pool memory read loop, one entry per cycle.
// Reset:
//   rst_n (sync, active low) clears control state and starts a sweep that
//   zeroes the column head table, with busy held high throughout.
//   Pool contents are not cleared; the used count makes them safe.
// ----------------------------------------------------------------------------
module sparse_pattern_insert_core
  import spi_pkg::*;
#(
  parameter int NUM_DOF    = 4096,
  parameter int POOL_DEPTH = 16384
) (
  input  logic                clk,
  input  logic                rst_n,
  // input items
  input  logic                start,
  output logic                busy,
  input  logic [DOF_W-1:0]    in_dof_a,
  input  logic [DOF_W-1:0]    in_dof_b,
  // results
  output logic                out_valid,
  output logic [SLOT_W_O-1:0] out_entry_slot,
  output logic                out_is_new,
  output logic                out_overflow,
  output logic [SLOT_W_O-1:0] out_entries_used,
  // config
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [LIMIT_W-1:0]  cfg_pool_limit
);

  localparam int SLOT_W = $clog2(POOL_DEPTH + 1);  // 1-based slot, 0 = none
  localparam int PA_W   = $clog2(POOL_DEPTH);
  localparam int CI_W   = $clog2(NUM_DOF);
  localparam int SC_W   = $clog2(POOL_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_WALK,
    ST_LINK0
  } state_t;

  state_t state_r, state_nxt;

  logic [DOF_W-1:0]    row_r, row_nxt;
  logic [CI_W-1:0]     col_idx_r, col_idx_nxt;
  logic [SLOT_W-1:0]   cur_r, cur_nxt;
  logic [SC_W-1:0]     steps_r, steps_nxt;
  logic [SLOT_W-1:0]   used_r, used_nxt;
  logic [LIMIT_W-1:0]  limit_r;

  logic                out_valid_r, out_valid_nxt;
  logic [SLOT_W_O-1:0] out_slot_r, out_slot_nxt;
  logic                out_new_r, out_new_nxt;
  logic                out_ovf_r, out_ovf_nxt;
  logic [SLOT_W_O-1:0] out_used_r, out_used_nxt;

  // memory side
  logic [CI_W-1:0]     hd_rd_addr;
  logic [SLOT_W-1:0]   hd_rd_data;
  logic                hd_we;
  logic [SLOT_W-1:0]   hd_wdata;
  logic                clearing;

  logic [PA_W-1:0]     pl_rd_addr;
  logic [DOF_W-1:0]    pl_rd_row;
  logic [SLOT_W-1:0]   pl_rd_link;
  pool_wen_t           pl_wen;
  logic [PA_W-1:0]     pl_link_waddr;
  logic [SLOT_W-1:0]   pl_link_wdata;

  // input ordering
  logic                accept;
  logic [DOF_W-1:0]    in_row, in_col;
  logic                in_ok;
  logic                full;
  logic [SLOT_W-1:0]   new_slot;

  function automatic logic slot_ok(input logic [SLOT_W-1:0] s);
    return (s != '0) && (32'(s) <= POOL_DEPTH);
  endfunction

  assign busy      = clearing || (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign in_row = (in_dof_a < in_dof_b) ? in_dof_a : in_dof_b;
  assign in_col = (in_dof_a < in_dof_b) ? in_dof_b : in_dof_a;
  assign in_ok  = (in_row != '0) && (32'(in_col) <= NUM_DOF);

  // effective limit is pool_limit saturated to the pool depth
  assign full     = (32'(used_r) >= 32'(limit_r)) || (32'(used_r) >= POOL_DEPTH);
  assign new_slot = used_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_idx_nxt   = col_idx_r;
    cur_nxt       = cur_r;
    steps_nxt     = steps_r;
    used_nxt      = used_r;
    out_valid_nxt = 1'b0;
    out_slot_nxt  = out_slot_r;
    out_new_nxt   = 1'b0;
    out_ovf_nxt   = 1'b0;
    out_used_nxt  = out_used_r;

    hd_rd_addr    = CI_W'(in_col - 1'b1);
    hd_we         = 1'b0;
    hd_wdata      = new_slot;
    pl_rd_addr    = PA_W'(hd_rd_data - 1'b1);
    pl_wen        = '0;
    pl_link_waddr = PA_W'(used_r);
    pl_link_wdata = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          row_nxt     = in_row;
          col_idx_nxt = CI_W'(in_col - 1'b1);
          if (in_ok) begin
            state_nxt = ST_HEAD;
          end else begin
            // pair ignored
            out_valid_nxt = 1'b1;
            out_slot_nxt  = '0;
            out_used_nxt  = SLOT_W_O'(used_r);
          end
        end
      end

      ST_HEAD: begin
        if (!slot_ok(hd_rd_data)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (full) begin
            out_slot_nxt = '0;
            out_ovf_nxt  = 1'b1;
            out_used_nxt = SLOT_W_O'(used_r);
          end else begin
            // new chain: head, row and end link written in the same cycle
            hd_we        = 1'b1;
            pl_wen.row   = 1'b1;
            pl_wen.link  = 1'b1;
            used_nxt     = new_slot;
            out_slot_nxt = SLOT_W_O'(new_slot);
            out_new_nxt  = 1'b1;
            out_used_nxt = SLOT_W_O'(new_slot);
          end
        end else begin
          cur_nxt   = hd_rd_data;
          steps_nxt = '0;
          state_nxt = ST_WALK;
        end
      end

      ST_WALK: begin
        pl_rd_addr = PA_W'(pl_rd_link - 1'b1);
        if (pl_rd_row == row_r) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = SLOT_W_O'(cur_r);
          out_used_nxt  = SLOT_W_O'(used_r);
          state_nxt     = ST_IDLE;
        end else if (!slot_ok(pl_rd_link)) begin
          out_valid_nxt = 1'b1;
          if (full) begin
            out_slot_nxt = '0;
            out_ovf_nxt  = 1'b1;
            out_used_nxt = SLOT_W_O'(used_r);
            state_nxt    = ST_IDLE;
          end else begin
            // append: row and tail link now, new entry's end link next cycle
            pl_wen.row    = 1'b1;
            pl_wen.link   = 1'b1;
            pl_link_waddr = PA_W'(cur_r - 1'b1);
            pl_link_wdata = new_slot;
            used_nxt      = new_slot;
            out_slot_nxt  = SLOT_W_O'(new_slot);
            out_new_nxt   = 1'b1;
            out_used_nxt  = SLOT_W_O'(new_slot);
            state_nxt     = ST_LINK0;
          end
        end else if (steps_r == SC_W'(POOL_DEPTH - 1)) begin
          // walk bound hit: give up with no slot
          out_valid_nxt = 1'b1;
          out_slot_nxt  = '0;
          out_used_nxt  = SLOT_W_O'(used_r);
          state_nxt     = ST_IDLE;
        end else begin
          cur_nxt   = pl_rd_link;
          steps_nxt = steps_r + 1'b1;
        end
      end

      ST_LINK0: begin
        pl_wen.link   = 1'b1;
        pl_link_waddr = PA_W'(used_r - 1'b1);
        pl_link_wdata = '0;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= '0;
      col_idx_r   <= '0;
      cur_r       <= '0;
      steps_r     <= '0;
      used_r      <= '0;
      limit_r     <= LIMIT_RST;
      out_valid_r <= 1'b0;
      out_slot_r  <= '0;
      out_new_r   <= 1'b0;
      out_ovf_r   <= 1'b0;
      out_used_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_idx_r   <= col_idx_nxt;
      cur_r       <= cur_nxt;
      steps_r     <= steps_nxt;
      used_r      <= used_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_pool_limit;
      end
      out_valid_r <= out_valid_nxt;
      out_slot_r  <= out_slot_nxt;
      out_new_r   <= out_new_nxt;
      out_ovf_r   <= out_ovf_nxt;
      out_used_r  <= out_used_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_entry_slot   = out_slot_r;
  assign out_is_new       = out_new_r;
  assign out_overflow     = out_ovf_r;
  assign out_entries_used = out_used_r;

  spi_head_mem #(
    .DEPTH  (NUM_DOF),
    .SLOT_W (SLOT_W)
  ) u_head (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (hd_rd_addr),
    .rd_data  (hd_rd_data),
    .wr_en    (hd_we),
    .wr_addr  (col_idx_r),
    .wr_data  (hd_wdata),
    .clearing (clearing)
  );

  spi_pool_mem #(
    .DEPTH  (POOL_DEPTH),
    .SLOT_W (SLOT_W)
  ) u_pool (
    .clk        (clk),
    .rd_addr    (pl_rd_addr),
    .rd_row     (pl_rd_row),
    .rd_link    (pl_rd_link),
    .wen        (pl_wen),
    .row_waddr  (PA_W'(used_r)),
    .row_wdata  (row_r),
    .link_waddr (pl_link_waddr),
    .link_wdata (pl_link_wdata)
  );

endmodule

// ===== dv/tb_sparse_pattern_insert_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sparse_pattern_insert_core
// Self-checking bench for the sparse pattern insert core. A predictor tracks
// the column chains and the pool fill. It works out slot, new/found, overflow
// and pool usage for every accepted dof pair, and each strobed result is
// compared against it in order. Stimulus has a directed part (corner dofs,
// chain walks, limit refusals) and then random bursts under several pool
// limits.
// ----------------------------------------------------------------------------
module tb_sparse_pattern_insert_core;
  import spi_pkg::*;

  localparam int NUM_DOF     = 4096;
  localparam int POOL_DEPTH  = 16384;
  localparam int CYCLE_LIMIT = 1000000;

  // What one item should produce
  typedef struct packed {
    logic [SLOT_W_O-1:0] slot;
    logic                fresh;
    logic                refused;
    logic [SLOT_W_O-1:0] used;
  } entry_result_t;

  // --------------------------------------------------------------------------
  // Pattern tracker: own copy of column heads, pool rows/links and fill count.
  // Unwritten pool entries read as zero; a correct run never reaches them.
  // --------------------------------------------------------------------------
  class pattern_tracker;
    bit [SLOT_W_O-1:0] column_head [NUM_DOF];
    bit [DOF_W-1:0]    entry_row   [POOL_DEPTH];
    bit [SLOT_W_O-1:0] entry_link  [POOL_DEPTH];
    bit [SLOT_W_O-1:0] used_count;
    bit [LIMIT_W-1:0]  pool_limit;
    entry_result_t     pending[$];
    int errors, n_items, n_checked, n_new, n_found, n_refused, n_ignored;

    function new();
      pool_limit = LIMIT_RST;
    endfunction

    function void set_limit(input logic [LIMIT_W-1:0] v);
      pool_limit = v;
    endfunction

    function bit slot_in_pool(input logic [SLOT_W_O-1:0] s);
      return (s >= 1) && (s <= POOL_DEPTH);
    endfunction

    // next free slot, or 0 once the (saturated) limit is reached
    function logic [SLOT_W_O-1:0] grab_slot(input logic [DOF_W-1:0] row);
      logic [LIMIT_W-1:0] eff;
      eff = (pool_limit > POOL_DEPTH) ? LIMIT_W'(POOL_DEPTH) : pool_limit;
      if (used_count >= eff) return '0;
      used_count++;
      entry_row[used_count-1]  = row;
      entry_link[used_count-1] = '0;
      return used_count;
    endfunction

    function void note_pair(input logic [DOF_W-1:0] a, input logic [DOF_W-1:0] b);
      logic [DOF_W-1:0]    row, col;
      logic [SLOT_W_O-1:0] cur, nxt;
      entry_result_t       r;
      int                  steps;
      r   = '0;
      row = (a < b) ? a : b;
      col = (a < b) ? b : a;
      n_items++;
      if (row >= 1 && col <= NUM_DOF) begin
        cur = column_head[col-1];
        if (!slot_in_pool(cur)) begin
          r.slot = grab_slot(row);
          if (r.slot != 0) column_head[col-1] = r.slot;
          else r.refused = 1'b1;
          r.fresh = (r.slot != 0);
        end else begin
          for (steps = 0; steps < POOL_DEPTH; steps++) begin
            if (entry_row[cur-1] == row) begin
              r.slot = cur;
              break;
            end
            nxt = entry_link[cur-1];
            if (!slot_in_pool(nxt)) begin
              r.slot = grab_slot(row);
              if (r.slot != 0) entry_link[cur-1] = r.slot;
              else r.refused = 1'b1;
              r.fresh = (r.slot != 0);
              break;
            end
            cur = nxt;
          end
        end
      end else begin
        n_ignored++;
      end
      r.used = used_count;
      if (r.fresh) n_new++;
      else if (r.refused) n_refused++;
      else if (r.slot != 0) n_found++;
      pending.push_back(r);
    endfunction

    task report(input string msg);
      errors++;
      $display("[%0t] MISMATCH result %0d: %s", $time, n_checked, msg);
    endtask

    task check_entry(input logic [SLOT_W_O-1:0] slot, input logic fresh,
                     input logic refused, input logic [SLOT_W_O-1:0] used);
      entry_result_t want;
      if (pending.size() == 0) begin
        report("result strobed with no item outstanding");
        return;
      end
      want = pending.pop_front();
      if (slot !== want.slot)
        report($sformatf("entry_slot %0d, predicted %0d", slot, want.slot));
      if (fresh !== want.fresh)
        report($sformatf("is_new %b, predicted %b", fresh, want.fresh));
      if (refused !== want.refused)
        report($sformatf("overflow %b, predicted %b", refused, want.refused));
      if (used !== want.used)
        report($sformatf("entries_used %0d, predicted %0d", used, want.used));
      n_checked++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [DOF_W-1:0]    in_dof_a = '0;
  logic [DOF_W-1:0]    in_dof_b = '0;
  logic                out_valid;
  logic [SLOT_W_O-1:0] out_entry_slot;
  logic                out_is_new;
  logic                out_overflow;
  logic [SLOT_W_O-1:0] out_entries_used;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [LIMIT_W-1:0]  cfg_pool_limit = '0;

  pattern_tracker      tracker = new();
  logic [2*DOF_W-1:0]  recent_pairs[$];   // valid pairs seen, replayed as hits
  int                  cycles = 0;
  int                  n_cfg_writes = 0;

  always #4 clk = ~clk;

  sparse_pattern_insert_core #(
    .NUM_DOF    (NUM_DOF),
    .POOL_DEPTH (POOL_DEPTH)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_dof_a         (in_dof_a),
    .in_dof_b         (in_dof_b),
    .out_valid        (out_valid),
    .out_entry_slot   (out_entry_slot),
    .out_is_new       (out_is_new),
    .out_overflow     (out_overflow),
    .out_entries_used (out_entries_used),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_pool_limit   (cfg_pool_limit)
  );

  // Watchdog: covers the reset sweep and long chain walks many times over
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Results can't be held off: take every strobe at the edge that ends it
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      tracker.check_entry(out_entry_slot, out_is_new, out_overflow, out_entries_used);
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Present one pair; start stays high on return so a burst can continue
  // without a low/high pair of writes in the same step.
  task automatic send_pair(input logic [DOF_W-1:0] a, input logic [DOF_W-1:0] b);
    in_dof_a <= a;
    in_dof_b <= b;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    tracker.note_pair(a, b);
    if (a >= 1 && a <= NUM_DOF && b >= 1 && b <= NUM_DOF) begin
      recent_pairs.push_back({a, b});
      if (recent_pairs.size() > 64) void'(recent_pairs.pop_front());
    end
  endtask

  task automatic pause_sender(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Idle = nothing outstanding, a wait for the trailing link write,
  // and busy low (also covers the head-table sweep after reset).
  task automatic wait_drained();
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_pool_limit(input logic [LIMIT_W-1:0] v);
    cfg_pool_limit <= v;
    cfg_valid      <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_limit(v);
    n_cfg_writes++;
  endtask

  // dofs packed near both ends so chains get long and pairs repeat
  function automatic logic [DOF_W-1:0] cluster_dof();
    return $urandom_range(0, 1) ? DOF_W'($urandom_range(1, 20))
                                : DOF_W'($urandom_range(NUM_DOF - 19, NUM_DOF));
  endfunction

  task automatic pick_pair(output logic [DOF_W-1:0] a, output logic [DOF_W-1:0] b,
                           output bit valid);
    int                 mode;
    logic [2*DOF_W-1:0] p;
    mode  = $urandom_range(0, 99);
    valid = 1'b1;
    if (mode < 45) begin
      a = cluster_dof();
      b = cluster_dof();
    end else if (mode < 65 && recent_pairs.size() != 0) begin
      // replay, sometimes swapped: finds the existing slot unless it was refused
      p = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
      if ($urandom_range(0, 1)) {a, b} = p;
      else {b, a} = p;
    end else if (mode < 88) begin
      a = DOF_W'($urandom_range(1, NUM_DOF));
      b = DOF_W'($urandom_range(1, NUM_DOF));
    end else begin
      // out of range on at least one side: ignored by the block
      a = ($urandom_range(0, 3) == 0) ? '0 : DOF_W'($urandom_range(NUM_DOF + 1, 8191));
      b = DOF_W'($urandom_range(0, 8191));
      if ($urandom_range(0, 1)) {a, b} = {b, a};
      valid = 1'b0;
    end
  endtask

  // Random bursts with random gaps; ignored pairs don't count toward n
  task automatic run_random(input int n);
    int               done, burst;
    logic [DOF_W-1:0] a, b;
    bit               valid;
    done = 0;
    while (done < n) begin
      burst = ($urandom_range(0, 9) == 0) ? 30 : $urandom_range(1, 12);
      repeat (burst) begin
        if (done < n) begin
          pick_pair(a, b, valid);
          send_pair(a, b);
          if (valid) done++;
        end
      end
      pause_sender($urandom_range(1, 6));
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [DOF_W-1:0] dir_a [21];
    logic [DOF_W-1:0] dir_b [21];
    // diagonal, repeat, both ends, swapped order, out of range (zero, just
    // above, all ones), a chain on column 10 hit at head/middle/tail and
    // appended after a walk, alternating bit patterns
    dir_a = '{1, 1, 4096, 1, 4096, 0, 5, 0, 4097, 8191, 3,
              4096, 10, 3, 10, 10, 2, 10, 7, 4095, 2730};
    dir_b = '{1, 1, 1, 4096, 4096, 5, 0, 0, 3, 8191, 8191,
              4097, 2, 10, 10, 3, 10, 10, 10, 4096, 5461};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();                        // head-table clearing sweep
    write_pool_limit(LIMIT_RST);

    for (int i = 0; i < 21; i++) begin
      send_pair(dir_a[i], dir_b[i]);
      if (i == 9) pause_sender(3);
    end
    pause_sender(2);

    // limit at the current fill: new pair refused, existing pair still found
    wait_drained();
    write_pool_limit(tracker.used_count);
    send_pair(9, 10);
    send_pair(3, 10);
    pause_sender(1);

    // limit zero refuses even an empty column's first entry
    wait_drained();
    write_pool_limit('0);
    send_pair(1, 2);
    send_pair(1, 1);
    pause_sender(1);

    // all-ones limit saturates to the pool depth
    wait_drained();
    write_pool_limit('1);
    run_random(100);

    // tight limit: pool fills partway through the phase
    wait_drained();
    write_pool_limit(tracker.used_count + LIMIT_W'(25));
    run_random(100);

    wait_drained();
    write_pool_limit(LIMIT_W'(1));
    run_random(100);

    wait_drained();
    write_pool_limit(LIMIT_W'($urandom_range(tracker.used_count, tracker.used_count + 80)));
    run_random(100);

    wait_drained();
    write_pool_limit(LIMIT_RST);
    run_random(100);

    wait_drained();
    repeat (20) @(posedge clk);

    $display("Run: %0d pairs sent, %0d results checked, %0d limit writes, %0d pool entries.",
             tracker.n_items, tracker.n_checked, n_cfg_writes, tracker.used_count);
    $display("Outcomes: %0d new, %0d found, %0d refused at limit, %0d out of range.",
             tracker.n_new, tracker.n_found, tracker.n_refused, tracker.n_ignored);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
